// ----- rtl/bucket_chain_pool_manager_unit_defines.svh -----
// assertion macros shared by the bucket chain pool manager rtl
// no dependencies; included by the files that carry assertions
`ifndef BUCKET_CHAIN_POOL_MANAGER_UNIT_DEFINES_SVH
`define BUCKET_CHAIN_POOL_MANAGER_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define BCPM_ASSERT_HOLDS(lbl, clk_s, rst_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BCPM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define BCPM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bcpm_pkg.sv -----
// shared types and constants of the bucket chain pool manager
// no dependencies; imported by every module of the block
`default_nettype none

package bcpm_pkg;

	localparam int unsigned POOL_BUCKETS_DEF     = 1024;
	localparam int unsigned SLOTS_PER_BUCKET_DEF = 8;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 14;
	localparam int unsigned VALUE_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd16383;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_ALLOC  = 3'd0;
	localparam cmd_t CMD_FREE   = 3'd1;
	localparam cmd_t CMD_FCHAIN = 3'd2;
	localparam cmd_t CMD_LENGTH = 3'd3;
	localparam cmd_t CMD_APPEND = 3'd4;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_NULL = 2'd1;
	localparam status_t ST_PAST = 2'd2;
	localparam status_t ST_FULL = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic idle;
		logic load;
		logic decode;
		logic grab;
		logic pop;
		logic fchain_step;
		logic sum_step;
		logic find_step;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic chk_ok;
		logic fh_ok;
		logic walk_end;
		logic nx_past;
		logic found;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/bcpm_ctrl.sv -----
// command sequencer of the bucket chain pool manager
// depends on bcpm_pkg and the shared assertion macro header
`default_nettype none
`include "bucket_chain_pool_manager_unit_defines.svh"

module bcpm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  bcpm_pkg::sts_t  sts,
	output bcpm_pkg::ctl_t  ctl
);
	import bcpm_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_POP    = 8'b0000_0100,
		S_FCHAIN = 8'b0000_1000,
		S_SUM    = 8'b0001_0000,
		S_FIND   = 8'b0010_0000,
		S_GRAB   = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_ALLOC:  state_d = sts.fh_ok ? S_POP : S_FIN;
					CMD_FCHAIN: state_d = sts.chk_ok ? S_FCHAIN : S_FIN;
					CMD_LENGTH: state_d = sts.chk_ok ? S_SUM : S_FIN;
					CMD_APPEND: state_d = sts.chk_ok ? S_FIND : S_FIN;
					default:    state_d = S_FIN;
				endcase
			end
			S_POP: begin
				state_d = S_FIN;
			end
			S_FCHAIN: begin
				if (sts.nx_past || sts.walk_end) state_d = S_FIN;
			end
			S_SUM: begin
				if (sts.walk_end) state_d = (sts.cmd == CMD_APPEND) ? S_GRAB : S_FIN;
				else if (sts.nx_past) state_d = S_FIN;
			end
			S_FIND: begin
				if (sts.found) state_d = S_FIN;
				else if (sts.walk_end) state_d = S_SUM;
				else if (sts.nx_past) state_d = S_FIN;
			end
			S_GRAB: begin
				state_d = sts.fh_ok ? S_POP : S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		ctl.idle        = (state_q == S_IDLE);
		ctl.load        = (state_q == S_IDLE) && in_valid;
		ctl.decode      = (state_q == S_DECODE);
		ctl.grab        = (state_q == S_GRAB);
		ctl.pop         = (state_q == S_POP);
		ctl.fchain_step = (state_q == S_FCHAIN);
		ctl.sum_step    = (state_q == S_SUM);
		ctl.find_step   = (state_q == S_FIND);
		ctl.finish      = (state_q == S_FIN);
	end

	`BCPM_ASSERT_NEXT(a_load_decodes, clk, arst_n, ctl.load, state_q == S_DECODE, "accepted word not decoded")
	`BCPM_ASSERT_NEXT(a_pop_finishes, clk, arst_n, state_q == S_POP, state_q == S_FIN, "pop did not finish")
	`BCPM_ASSERT_NEXT(a_fin_holds, clk, arst_n, ctl.finish && !sts.out_free, state_q == S_FIN, "result dropped while output busy")

endmodule

`default_nettype wire

// ----- rtl/bcpm_datapath.sv -----
// bucket memories, free list, high-water mark and result registers
// depends on bcpm_pkg and the shared assertion macro header
`default_nettype none
`include "bucket_chain_pool_manager_unit_defines.svh"

module bcpm_datapath #(
	parameter int unsigned POOL_BUCKETS     = bcpm_pkg::POOL_BUCKETS_DEF,
	parameter int unsigned SLOTS_PER_BUCKET = bcpm_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bcpm_pkg::ctl_t                       ctl,
	output bcpm_pkg::sts_t                       sts,
	input  logic [bcpm_pkg::CMD_W-1:0]           cmd,
	input  logic [$clog2(POOL_BUCKETS)-1:0]      bucket_index,
	input  logic signed [bcpm_pkg::VALUE_W-1:0]  value_in,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output bcpm_pkg::status_t                    status,
	output logic [$clog2(POOL_BUCKETS)-1:0]      bucket_out,
	output logic                                 new_head,
	output logic [bcpm_pkg::COUNT_W-1:0]         item_count
);
	import bcpm_pkg::*;

	localparam int unsigned IDX_W      = $clog2(POOL_BUCKETS);
	localparam int unsigned HW_W       = IDX_W + 1;
	localparam int unsigned FILL_W     = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int unsigned SLOT_DEPTH = POOL_BUCKETS * SLOTS_PER_BUCKET;
	localparam int unsigned SLOT_AW    = $clog2(SLOT_DEPTH);

	localparam logic [HW_W-1:0]    POOL_HW   = HW_W'(POOL_BUCKETS);
	localparam logic [HW_W-1:0]    STEP_LAST = HW_W'(POOL_BUCKETS - 1);
	localparam logic [FILL_W-1:0]  SLOTS_F   = FILL_W'(SLOTS_PER_BUCKET);
	localparam logic [SLOT_AW-1:0] SLOTS_A   = SLOT_AW'(SLOTS_PER_BUCKET);

	// bucket storage, contents undefined until written
	logic [IDX_W-1:0]   link_mem [POOL_BUCKETS];
	logic [FILL_W-1:0]  fill_mem [POOL_BUCKETS];
	logic [VALUE_W-1:0] slot_mem [SLOT_DEPTH];

	logic [IDX_W-1:0]   link_rd_q;
	logic [FILL_W-1:0]  fill_rd_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VALUE_W-1:0] val_q;
	logic [IDX_W-1:0]   free_head_q;
	logic [HW_W-1:0]    hw_q;
	logic [IDX_W-1:0]   cur_q;
	logic [HW_W-1:0]    steps_q;
	logic [COUNT_W-1:0] sum_q;

	status_t            res_status_q;
	logic [IDX_W-1:0]   res_bucket_q;
	logic               res_new_head_q;
	logic [COUNT_W-1:0] res_count_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [IDX_W-1:0]   out_bucket_q;
	logic               out_new_head_q;
	logic [COUNT_W-1:0] out_count_q;

	status_t            chk_status;
	logic               chk_ok;
	logic               is_app;
	logic               fh_below;
	logic               fh_ok;
	logic               fresh_ok;
	logic               nx_zero;
	logic               nx_past;
	logic               step_last;
	logic               walk_end;
	logic               found;
	logic [COUNT_W:0]   sum_wide;
	logic [COUNT_W-1:0] sum_next;
	logic               take;
	logic               take_fresh;
	logic               restart;
	logic               out_free;
	logic               load_out;
	logic               hw_ok;
	logic               full_clean;
	logic [IDX_W-1:0]   hw_idx;
	logic [IDX_W-1:0]   rd_addr;

	logic               lk_we;
	logic [IDX_W-1:0]   lk_wa;
	logic [IDX_W-1:0]   lk_wd;
	logic               fl_we;
	logic [IDX_W-1:0]   fl_wa;
	logic [FILL_W-1:0]  fl_wd;
	logic               sl_we;
	logic [IDX_W-1:0]   sl_bucket;
	logic [FILL_W-1:0]  sl_fill;
	logic [SLOT_AW-1:0] sl_wa;

	// index checks against the high-water mark
	always_comb begin
		if (idx_q == '0) chk_status = ST_NULL;
		else if ({1'b0, idx_q} >= hw_q) chk_status = ST_PAST;
		else chk_status = ST_OK;
	end

	assign chk_ok    = (chk_status == ST_OK);
	assign is_app    = (cmd_q == CMD_APPEND);
	assign fh_below  = ({1'b0, free_head_q} < hw_q);
	assign fh_ok     = (free_head_q != '0) && fh_below;
	assign fresh_ok  = (hw_q < POOL_HW);
	assign hw_idx    = hw_q[IDX_W-1:0];

	// walk step on the bucket whose link and fill were read last cycle
	assign nx_zero   = (link_rd_q == '0);
	assign nx_past   = ({1'b0, link_rd_q} >= hw_q);
	assign step_last = (steps_q == STEP_LAST);
	assign walk_end  = nx_zero || step_last;
	assign found     = (fill_rd_q < SLOTS_F);

	// saturating running length
	assign sum_wide  = {1'b0, sum_q} + (COUNT_W + 1)'(fill_rd_q);
	assign sum_next  = (sum_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_wide[COUNT_W-1:0];

	assign take       = (ctl.decode && (cmd_q == CMD_ALLOC)) || ctl.grab;
	assign take_fresh = take && !fh_ok && fresh_ok;
	assign restart    = ctl.find_step && !found && walk_end;

	assign out_free = !out_valid_q || !out_stall;
	assign load_out = ctl.finish && out_free;

	always_comb begin
		rd_addr = idx_q;
		if (take) rd_addr = free_head_q;
		else if (ctl.fchain_step || ctl.sum_step || (ctl.find_step && !restart))
			rd_addr = link_rd_q;
	end

	// memory write selection
	always_comb begin
		lk_we     = 1'b0;
		lk_wa     = idx_q;
		lk_wd     = '0;
		fl_we     = 1'b0;
		fl_wa     = idx_q;
		fl_wd     = '0;
		sl_we     = 1'b0;
		sl_bucket = idx_q;
		sl_fill   = '0;
		if (take_fresh) begin
			lk_we     = 1'b1;
			lk_wa     = hw_idx;
			lk_wd     = is_app ? idx_q : '0;
			fl_we     = 1'b1;
			fl_wa     = hw_idx;
			fl_wd     = is_app ? FILL_W'(1) : '0;
			sl_we     = is_app;
			sl_bucket = hw_idx;
		end
		if (ctl.pop) begin
			lk_we     = 1'b1;
			lk_wa     = free_head_q;
			lk_wd     = is_app ? idx_q : '0;
			fl_we     = 1'b1;
			fl_wa     = free_head_q;
			fl_wd     = is_app ? FILL_W'(1) : '0;
			sl_we     = is_app;
			sl_bucket = free_head_q;
		end
		if (ctl.decode && (cmd_q == CMD_FREE) && chk_ok) begin
			lk_we = 1'b1;
			lk_wa = idx_q;
			lk_wd = free_head_q;
		end
		if (ctl.fchain_step) begin
			lk_we = 1'b1;
			lk_wa = cur_q;
			lk_wd = free_head_q;
		end
		if (ctl.find_step && found) begin
			fl_we     = 1'b1;
			fl_wa     = cur_q;
			fl_wd     = fill_rd_q + FILL_W'(1);
			sl_we     = 1'b1;
			sl_bucket = cur_q;
			sl_fill   = fill_rd_q;
		end
	end

	assign sl_wa = SLOT_AW'(sl_bucket) * SLOTS_A + SLOT_AW'(sl_fill);

	// one write and one registered read per link and fill memory, the slot memory is
	// write only; a read of the entry written in the same cycle returns the new data
	always_ff @(posedge clk) begin
		if (lk_we) link_mem[lk_wa] <= lk_wd;
		if (lk_we && (lk_wa == rd_addr)) link_rd_q <= lk_wd;
		else link_rd_q <= link_mem[rd_addr];
		if (fl_we) fill_mem[fl_wa] <= fl_wd;
		if (fl_we && (fl_wa == rd_addr)) fill_rd_q <= fl_wd;
		else fill_rd_q <= fill_mem[rd_addr];
		if (sl_we) slot_mem[sl_wa] <= val_q;
	end

	// pool state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			hw_q        <= HW_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.decode && (cmd_q == CMD_FREE) && chk_ok) free_head_q <= idx_q;
			if (ctl.fchain_step) free_head_q <= cur_q;
			if (ctl.pop) free_head_q <= link_rd_q;
			if (take_fresh) hw_q <= hw_q + HW_W'(1);
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// command, walk and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			idx_q <= bucket_index;
			val_q <= $unsigned(value_in);
		end
		if (ctl.decode) begin
			res_status_q   <= ST_OK;
			res_bucket_q   <= '0;
			res_new_head_q <= 1'b0;
			res_count_q    <= '0;
			cur_q          <= idx_q;
			steps_q        <= '0;
			sum_q          <= '0;
			case (cmd_q)
				CMD_FREE, CMD_FCHAIN, CMD_LENGTH, CMD_APPEND: res_status_q <= chk_status;
				default: res_status_q <= ST_OK;
			endcase
		end
		if (take && !fh_ok) begin
			if (fresh_ok) begin
				res_status_q   <= ST_OK;
				res_bucket_q   <= hw_idx;
				res_new_head_q <= is_app;
			end else begin
				res_status_q   <= ST_FULL;
				res_bucket_q   <= '0;
				res_new_head_q <= 1'b0;
			end
		end
		if (ctl.pop) begin
			res_status_q   <= ST_OK;
			res_bucket_q   <= free_head_q;
			res_new_head_q <= is_app;
		end
		if (ctl.fchain_step) begin
			cur_q   <= link_rd_q;
			steps_q <= steps_q + HW_W'(1);
			if (nx_past) res_status_q <= ST_PAST;
		end
		if (ctl.sum_step) begin
			sum_q   <= sum_next;
			cur_q   <= link_rd_q;
			steps_q <= steps_q + HW_W'(1);
			if (walk_end) res_count_q <= sum_next;
			else if (nx_past) begin
				res_status_q <= ST_PAST;
				res_count_q  <= '0;
			end
		end
		if (ctl.find_step) begin
			if (found) res_bucket_q <= cur_q;
			else if (walk_end) begin
				// chain full: sum it from the head before taking a new bucket
				cur_q   <= idx_q;
				steps_q <= '0;
				sum_q   <= '0;
			end else begin
				cur_q   <= link_rd_q;
				steps_q <= steps_q + HW_W'(1);
				if (nx_past) res_status_q <= ST_PAST;
			end
		end
		if (load_out) begin
			out_status_q   <= res_status_q;
			out_bucket_q   <= res_bucket_q;
			out_new_head_q <= res_new_head_q;
			out_count_q    <= res_count_q;
		end
	end

	always_comb begin
		sts.cmd      = cmd_q;
		sts.chk_ok   = chk_ok;
		sts.fh_ok    = fh_ok;
		sts.walk_end = walk_end;
		sts.nx_past  = nx_past;
		sts.found    = found;
		sts.out_free = out_free;
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign bucket_out = out_bucket_q;
	assign new_head   = out_new_head_q;
	assign item_count = out_count_q;

	assign hw_ok      = (hw_q != '0) && (hw_q <= POOL_HW);
	assign full_clean = (out_bucket_q == '0) && !out_new_head_q;

	`BCPM_ASSERT_HOLDS(a_hw_range, clk, arst_n, hw_ok, "high-water mark out of range")
	`BCPM_ASSERT_HOLDS(a_fh_range, clk, arst_n, (free_head_q == '0) || fh_below, "free head past high-water mark")
	`BCPM_ASSERT_IMP(a_full_clean, clk, arst_n, out_valid_q && (out_status_q == ST_FULL), full_clean, "pool full result carries a bucket")

endmodule

`default_nettype wire

// ----- rtl/bucket_chain_pool_manager_unit.sv -----
// top level of the bucket chain pool manager
// depends on bcpm_pkg, bcpm_ctrl and bcpm_datapath
//
// usage
// - input channel: in_valid / in_stall carry one command word (cmd, bucket_index,
//   value_in); output channel: out_valid / out_stall carry one result word
//   (status, bucket_out, new_head, item_count) for every command word
// - a word moves on a rising edge with valid high and stall low
// - one command at a time; in_stall low only when idle
// - free chain and length walk one bucket per cycle
// - append walks to the first bucket with room; when the chain is full it walks
//   it again to sum the length
// - the walk rate is set by the link and fill memories: one registered read per
//   cycle, whose data addresses the next read
// - the result sits in an output register; the next command word is accepted
//   while it waits, and a stalled receiver only holds the following result
// - reset: free list empty, high-water mark at one (bucket zero is the null
//   index), no result pending; bucket memories are not cleared
`default_nettype none

module bucket_chain_pool_manager_unit #(
	parameter int unsigned POOL_BUCKETS     = bcpm_pkg::POOL_BUCKETS_DEF,
	parameter int unsigned SLOTS_PER_BUCKET = bcpm_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command words
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [bcpm_pkg::CMD_W-1:0]           cmd,
	input  logic [$clog2(POOL_BUCKETS)-1:0]      bucket_index,
	input  logic signed [bcpm_pkg::VALUE_W-1:0]  value_in,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output bcpm_pkg::status_t                    status,
	output logic [$clog2(POOL_BUCKETS)-1:0]      bucket_out,
	output logic                                 new_head,
	output logic [bcpm_pkg::COUNT_W-1:0]         item_count
);
	import bcpm_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer: decode, walk steps, bucket take and result hand-off
	bcpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.ctl      (ctl)
	);

	// memories, free list, high-water mark and output register
	bcpm_datapath #(
		.POOL_BUCKETS     (POOL_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.bucket_index (bucket_index),
		.value_in     (value_in),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.bucket_out   (bucket_out),
		.new_head     (new_head),
		.item_count   (item_count)
	);

	// a command word is taken only by an idle sequencer
	assign in_stall = !ctl.idle;

endmodule

`default_nettype wire
